// ===== sv/celg_pkg.sv =====
// Shared types, widths and constants for the cross-entropy loss and gradient core.
// Holds the natural-log lookup table built at elaboration time.
// No dependencies; every other file of the core imports this package.
package celg_pkg;

    // Class and field widths
    localparam int MAX_CLASSES   = 4096;
    localparam int POS_W         = $clog2(MAX_CLASSES);
    localparam int CNT_W         = POS_W + 1;
    localparam int MIN_CLASSES   = 2;
    localparam int POST_W        = 17;
    localparam int GRAD_W        = 18;
    localparam int LOSS_W        = 20;
    localparam int SEQ_ADD_W     = 8;
    localparam int TOTAL_LOSS_W  = 48;
    localparam int COUNT_W       = 32;
    localparam int ONE_Q16       = 65536;

    // Log table
    localparam int LOG_TABLE_BITS = 8;
    localparam int TAB_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int LN_W           = 16;
    localparam int LN2_Q16        = 45426;
    localparam int SHIFT_W        = $clog2(POST_W);
    localparam int SERIES_TERMS   = 20;

    // Stream and register port widths
    localparam int IN_FIELDS_W   = POST_W + POS_W + SEQ_ADD_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = GRAD_W + LOSS_W + TOTAL_LOSS_W + 3 * COUNT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = 2;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [CNT_W-1:0] CLASS_COUNT_RESET = CNT_W'(MAX_CLASSES);

    // Register index, taken from the word address of the configuration port.
    typedef enum logic [0:0] {
        REG_CLASS_COUNT = 1'b0
    } celg_reg_t;

    typedef logic [LN_W-1:0] ln_tab_t [TAB_SIZE];

    // ln(1 + i/2^B) in Q.16 through the atanh series, all in integers.
    function automatic ln_tab_t build_ln_tab();
        ln_tab_t     tab;
        logic [63:0] z;
        logic [63:0] zsq;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < TAB_SIZE; i++) begin
            z    = (64'(i) << 30) / 64'(2 * TAB_SIZE + i);
            zsq  = (z * z) >> 30;
            term = z;
            sum  = '0;
            for (int k = 0; k < SERIES_TERMS; k++) begin
                sum  = sum + term / 64'(2 * k + 1);
                term = (term * zsq) >> 30;
            end
            tab[i] = LN_W'((2 * sum + 64'(1 << 13)) >> 14);
        end
        return tab;
    endfunction

    localparam ln_tab_t LN_TAB = build_ln_tab();

    // One input transaction.
    typedef struct packed {
        logic [POST_W-1:0]    posterior;
        logic [POS_W-1:0]     target_class;
        logic                 frame_mask;
        logic                 call_end;
        logic [SEQ_ADD_W-1:0] sequences_add;
    } celg_item_t;

    // Per-element result after the frame tracker.
    typedef struct packed {
        logic [GRAD_W-1:0]    gradient;
        logic                 frame_end;
        logic                 frame_correct;
        logic                 class_error;
        logic                 loss_en;
        logic                 call_end;
        logic [SEQ_ADD_W-1:0] sequences_add;
        logic [POST_W-1:0]    target_posterior;
    } celg_frame_res_t;

    // Per-element result after the loss unit.
    typedef struct packed {
        logic [GRAD_W-1:0]    gradient;
        logic                 frame_end;
        logic                 frame_correct;
        logic                 class_error;
        logic                 call_end;
        logic [SEQ_ADD_W-1:0] sequences_add;
        logic [LOSS_W-1:0]    frame_loss;
    } celg_loss_res_t;

    // Per-element fields of an output transaction.
    typedef struct packed {
        logic [GRAD_W-1:0] gradient;
        logic              frame_end;
        logic              frame_correct;
        logic [LOSS_W-1:0] frame_loss;
        logic              class_error;
    } celg_result_t;

    // Running totals shown on every output transaction.
    typedef struct packed {
        logic [TOTAL_LOSS_W-1:0] total_loss;
        logic [COUNT_W-1:0]      total_correct;
        logic [COUNT_W-1:0]      total_frames;
        logic [COUNT_W-1:0]      total_sequences;
    } celg_totals_t;

endpackage

// ===== sv/celg_frame.sv =====
// Input register and per-frame tracking: class position, argmax, target posterior,
// masked gradient and end-of-frame flags. Depends on celg_pkg.
module celg_frame (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  celg_pkg::celg_item_t       in_item,
    input  logic [celg_pkg::CNT_W-1:0] class_count,
    output logic                       res_valid,
    output celg_pkg::celg_frame_res_t  res
);
    import celg_pkg::*;

    celg_item_t      item_reg;
    logic            item_valid_reg;
    logic [POS_W-1:0]  class_position_reg;
    logic [POS_W-1:0]  class_position_next;
    logic [POST_W-1:0] best_value_reg;
    logic [POST_W-1:0] best_value_next;
    logic [POS_W-1:0]  best_index_reg;
    logic [POS_W-1:0]  best_index_next;
    logic [POST_W-1:0] target_posterior_reg;
    logic [POST_W-1:0] target_posterior_next;
    celg_frame_res_t res_reg;
    celg_frame_res_t res_next;
    logic            res_valid_reg;

    logic [CNT_W-1:0]  count_used;
    logic [CNT_W-1:0]  pos_inc;
    logic              first_elem;
    logic              hit;
    logic              frame_end;
    logic              class_error;
    logic [GRAD_W-1:0] grad_raw;

    always_comb
    begin
        if (class_count < CNT_W'(MIN_CLASSES))
            count_used = CNT_W'(MIN_CLASSES);
        else if (class_count > CNT_W'(MAX_CLASSES))
            count_used = CNT_W'(MAX_CLASSES);
        else
            count_used = class_count;

        first_elem  = (class_position_reg == '0);
        hit         = (class_position_reg == item_reg.target_class);
        pos_inc     = CNT_W'(class_position_reg) + CNT_W'(1);
        frame_end   = (pos_inc >= count_used);
        class_error = (CNT_W'(item_reg.target_class) >= count_used);

        if (first_elem)
        begin
            best_value_next = item_reg.posterior;
            best_index_next = '0;
        end
        else if (item_reg.posterior > best_value_reg)
        begin
            best_value_next = item_reg.posterior;
            best_index_next = class_position_reg;
        end
        else
        begin
            best_value_next = best_value_reg;
            best_index_next = best_index_reg;
        end

        if (hit)
            target_posterior_next = item_reg.posterior;
        else if (first_elem)
            target_posterior_next = '0;
        else
            target_posterior_next = target_posterior_reg;

        class_position_next = frame_end ? '0 : pos_inc[POS_W-1:0];

        // Two's complement difference; the all-positive case still fits the width.
        grad_raw = GRAD_W'(item_reg.posterior) - (hit ? GRAD_W'(ONE_Q16) : GRAD_W'(0));

        res_next.gradient         = item_reg.frame_mask ? grad_raw : '0;
        res_next.frame_end        = frame_end;
        res_next.class_error      = frame_end && class_error;
        res_next.loss_en          = frame_end && !class_error && item_reg.frame_mask;
        res_next.frame_correct    = frame_end && !class_error && item_reg.frame_mask &&
                                    (best_index_next == item_reg.target_class);
        res_next.call_end         = item_reg.call_end;
        res_next.sequences_add    = item_reg.sequences_add;
        res_next.target_posterior = target_posterior_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg       <= 1'b0;
            res_valid_reg        <= 1'b0;
            class_position_reg   <= '0;
            best_value_reg       <= '0;
            best_index_reg       <= '0;
            target_posterior_reg <= '0;
        end
        else if (adv)
        begin
            item_valid_reg <= in_valid;
            res_valid_reg  <= item_valid_reg;
            if (item_valid_reg)
            begin
                class_position_reg   <= class_position_next;
                best_value_reg       <= best_value_next;
                best_index_reg       <= best_index_next;
                target_posterior_reg <= target_posterior_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= in_item;
            res_reg  <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/celg_negln.sv =====
// Loss unit: normalizes the target posterior, looks up ln of the mantissa and
// forms -ln(p) in Q4.16 for a finished frame. Depends on celg_pkg.
module celg_negln (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  celg_pkg::celg_frame_res_t in_res,
    output logic                      res_valid,
    output celg_pkg::celg_loss_res_t  res
);
    import celg_pkg::*;

    logic [POST_W-1:0]         x_raw;
    logic [SHIFT_W-1:0]        shift_amt;
    logic [POST_W-1:0]         x_norm;
    logic [LOG_TABLE_BITS-1:0] tab_idx;
    logic [LN_W-1:0]           ln_val;
    logic [LOSS_W-1:0]         exp_part;
    logic [LOSS_W-1:0]         loss;
    celg_loss_res_t            res_reg;
    celg_loss_res_t            res_next;
    logic                      res_valid_reg;

    always_comb
    begin
        // A zero posterior is read as the smallest code.
        x_raw = (in_res.target_posterior == '0) ? POST_W'(1) : in_res.target_posterior;

        // Leading-zero count: the highest set bit decides the shift.
        shift_amt = '0;
        for (int b = 0; b < POST_W; b++)
        begin
            if (x_raw[b])
                shift_amt = SHIFT_W'(POST_W - 1 - b);
        end

        x_norm   = x_raw << shift_amt;
        tab_idx  = x_norm[POST_W-2 -: LOG_TABLE_BITS];
        ln_val   = LN_TAB[tab_idx];
        exp_part = LOSS_W'(shift_amt) * LOSS_W'(LN2_Q16);
        loss     = (exp_part >= LOSS_W'(ln_val)) ? exp_part - LOSS_W'(ln_val) : '0;

        res_next.gradient      = in_res.gradient;
        res_next.frame_end     = in_res.frame_end;
        res_next.frame_correct = in_res.frame_correct;
        res_next.class_error   = in_res.class_error;
        res_next.call_end      = in_res.call_end;
        res_next.sequences_add = in_res.sequences_add;
        res_next.frame_loss    = in_res.loss_en ? loss : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/celg_totals.sv =====
// Saturating running totals and the output result register.
// Depends on celg_pkg.
module celg_totals (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  celg_pkg::celg_loss_res_t in_res,
    output logic                     out_valid,
    output celg_pkg::celg_result_t   result,
    output celg_pkg::celg_totals_t   totals
);
    import celg_pkg::*;

    localparam logic [TOTAL_LOSS_W-1:0] LOSS_SAT  = '1;
    localparam logic [COUNT_W-1:0]      COUNT_SAT = '1;

    logic [TOTAL_LOSS_W-1:0] loss_sum_reg;
    logic [TOTAL_LOSS_W-1:0] loss_sum_next;
    logic [COUNT_W-1:0]      correct_count_reg;
    logic [COUNT_W-1:0]      correct_count_next;
    logic [COUNT_W-1:0]      frame_count_reg;
    logic [COUNT_W-1:0]      frame_count_next;
    logic [COUNT_W-1:0]      sequence_count_reg;
    logic [COUNT_W-1:0]      sequence_count_next;
    logic [TOTAL_LOSS_W:0]   loss_wide;
    logic [COUNT_W:0]        seq_wide;
    celg_result_t            result_reg;
    celg_result_t            result_next;
    logic                    out_valid_reg;

    always_comb
    begin
        loss_wide = (TOTAL_LOSS_W + 1)'(loss_sum_reg) + (TOTAL_LOSS_W + 1)'(in_res.frame_loss);
        seq_wide  = (COUNT_W + 1)'(sequence_count_reg) + (COUNT_W + 1)'(in_res.sequences_add);

        loss_sum_next       = loss_sum_reg;
        correct_count_next  = correct_count_reg;
        frame_count_next    = frame_count_reg;
        sequence_count_next = sequence_count_reg;

        if (in_res.frame_end)
        begin
            loss_sum_next = loss_wide[TOTAL_LOSS_W] ? LOSS_SAT : loss_wide[TOTAL_LOSS_W-1:0];
            if (in_res.frame_correct && (correct_count_reg != COUNT_SAT))
                correct_count_next = correct_count_reg + COUNT_W'(1);
            if (frame_count_reg != COUNT_SAT)
                frame_count_next = frame_count_reg + COUNT_W'(1);
            if (in_res.call_end)
                sequence_count_next = seq_wide[COUNT_W] ? COUNT_SAT : seq_wide[COUNT_W-1:0];
        end

        result_next.gradient      = in_res.gradient;
        result_next.frame_end     = in_res.frame_end;
        result_next.frame_correct = in_res.frame_correct;
        result_next.frame_loss    = in_res.frame_loss;
        result_next.class_error   = in_res.class_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            loss_sum_reg       <= '0;
            correct_count_reg  <= '0;
            frame_count_reg    <= '0;
            sequence_count_reg <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= in_valid;
            if (in_valid)
            begin
                loss_sum_reg       <= loss_sum_next;
                correct_count_reg  <= correct_count_next;
                frame_count_reg    <= frame_count_next;
                sequence_count_reg <= sequence_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    // The totals only move when a new result is loaded, so they stand beside it.
    assign out_valid              = out_valid_reg;
    assign result                 = result_reg;
    assign totals.total_loss      = loss_sum_reg;
    assign totals.total_correct   = correct_count_reg;
    assign totals.total_frames    = frame_count_reg;
    assign totals.total_sequences = sequence_count_reg;

endmodule

// ===== sv/cross_entropy_loss_gradient_core.sv =====
// Top level of the softmax cross-entropy loss and gradient core.
// Instantiates celg_frame, celg_negln and celg_totals; depends on celg_pkg.
//
//   Channel  | Direction | Transaction carries
//   ---------+-----------+--------------------------------------------------------
//   s_axis   | in        | one class posterior with target, mask, call bookkeeping
//   m_axis   | out       | gradient, frame results and running totals
//   APB      | in/out    | class_count register at byte address 0
//
// The core takes one input transaction per clock while the pipe is not held and returns
// one output transaction for each. The result is offered after passing four registers
// (input register, frame tracker, loss unit, result register).
// The loss unit's normalize-and-lookup path sets the stage split.
// All stages advance together; when the result register is full and m_axis_tready is
// low the whole pipe holds and s_axis_tready drops in the same cycle.
// Reset clears the frame position, argmax state and all totals; class_count returns
// to 4096.
module cross_entropy_loss_gradient_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, from bit 0 up: posterior[16:0], target_class[28:17],
    // sequences_add[36:29], zero fill.
    input  logic [celg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: frame_mask.
    input  logic                                 s_axis_tuser,
    // tlast: call_end.
    input  logic                                 s_axis_tlast,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata, from bit 0 up: gradient[17:0], frame_loss[37:18], total_loss[85:38],
    // total_correct[117:86], total_frames[149:118], total_sequences[181:150], zero fill.
    output logic [celg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // tuser, from bit 0 up: frame_correct, class_error.
    output logic [celg_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    // tlast: frame_end.
    output logic                                 m_axis_tlast,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [celg_pkg::PADDR_W-1:0]         paddr,
    input  logic [celg_pkg::PDATA_W-1:0]         pwdata,
    output logic [celg_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import celg_pkg::*;

    logic             adv;
    logic [CNT_W-1:0] class_count_reg;
    celg_reg_t        reg_sel;
    celg_item_t       item;
    logic             frame_valid;
    celg_frame_res_t  frame_res;
    logic             loss_valid;
    celg_loss_res_t   loss_res;
    logic             out_valid;
    celg_result_t     result;
    celg_totals_t     totals;

    // Configuration port. Words sit at 4-byte steps, so bit 2 picks the register.
    // Writes must land only while the pipe is idle; the block does not enforce this and has no guard.
    assign pready  = 1'b1;
    assign reg_sel = celg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            class_count_reg <= CLASS_COUNT_RESET;
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_CLASS_COUNT: class_count_reg <= pwdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CLASS_COUNT: prdata = PDATA_W'(class_count_reg);
            default:         prdata = '0;
        endcase
    end

    // The pipe moves whenever the result register is empty or being drained.
    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    assign item.posterior     = s_axis_tdata[POST_W-1:0];
    assign item.target_class  = s_axis_tdata[POST_W +: POS_W];
    assign item.sequences_add = s_axis_tdata[POST_W + POS_W +: SEQ_ADD_W];
    assign item.frame_mask    = s_axis_tuser;
    assign item.call_end      = s_axis_tlast;

    celg_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (s_axis_tvalid),
        .in_item     (item),
        .class_count (class_count_reg),
        .res_valid   (frame_valid),
        .res         (frame_res)
    );

    celg_negln u_negln (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (frame_valid),
        .in_res    (frame_res),
        .res_valid (loss_valid),
        .res       (loss_res)
    );

    celg_totals u_totals (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (loss_valid),
        .in_res    (loss_res),
        .out_valid (out_valid),
        .result    (result),
        .totals    (totals)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tlast  = result.frame_end;
    assign m_axis_tuser  = {result.class_error, result.frame_correct};
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                            totals.total_sequences,
                            totals.total_frames,
                            totals.total_correct,
                            totals.total_loss,
                            result.frame_loss,
                            result.gradient};

endmodule

// ===== test/tb_cross_entropy_loss_gradient_core.sv =====
// Self-checking testbench for the cross-entropy loss and gradient core.
// Drives posteriors over the input stream, sets the class count over APB and compares
// every output transaction with a built-in predictor; depends on celg_pkg and the core.
module tb_cross_entropy_loss_gradient_core;

    timeunit 1ns;
    timeprecision 1ps;

    import celg_pkg::*;

    // Run shape. The phases below walk the class count through its extremes,
    // including values that the core clamps (0, 1 and 8191).
    localparam int RAND_ITEMS   = 1400;
    localparam int PHASE_COUNT  = 11;
    localparam int PHASE_ITEMS  = RAND_ITEMS / PHASE_COUNT;
    localparam int LONG_STALL   = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int DIR_ROWS     = 26;

    localparam logic [PADDR_W-1:0] CLASS_COUNT_ADDR = PADDR_W'(int'(REG_CLASS_COUNT) * 4);

    // Output tdata field offsets, from bit 0 up.
    localparam int LOSS_LO  = GRAD_W;
    localparam int TLOSS_LO = LOSS_LO + LOSS_W;
    localparam int TCORR_LO = TLOSS_LO + TOTAL_LOSS_W;
    localparam int TFRM_LO  = TCORR_LO + COUNT_W;
    localparam int TSEQ_LO  = TFRM_LO + COUNT_W;

    localparam logic [15:0] RX_PATTERN = 16'b1101_1011_0111_0010;

    localparam logic [CNT_W-1:0] PHASE_CFG [PHASE_COUNT] = '{
        13'd2, 13'd0, 13'd3, 13'd1, 13'd5, 13'd8, 13'd17, 13'd37, 13'd100, 13'd8191, 13'd6
    };

    // One output transaction as the predictor sees it.
    typedef struct packed {
        celg_result_t el;
        celg_totals_t tot;
    } ce_expect_t;

    // A directed stimulus row. When typed is set, the per-element fields of el are the
    // expected ones; the running totals always come from the predictor.
    typedef struct packed {
        celg_item_t   item;
        logic         typed;
        celg_result_t el;
    } dir_row_t;

    // Directed part, class count 4. Fields: posterior, target, mask, call_end, seq_add.
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // Target 0 holds exactly 1.0: zero gradient, correct, zero loss.
        '{'{17'd65536,  12'd0,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd0,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd0,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd0,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b1, 1'b1, 20'd0, 1'b0}},
        // Masked frame with posteriors above one; call ends with the largest add.
        '{'{17'd131071, 12'd3,    1'b0, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd131071, 12'd3,    1'b0, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd3,    1'b0, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd3,    1'b0, 1'b1, 8'd255}, 1'b1, '{18'h00000, 1'b1, 1'b0, 20'd0, 1'b0}},
        // Target out of range: no one-hot term, class error at frame end.
        '{'{17'd0,      12'd4095, 1'b1, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd131071, 12'd4095, 1'b1, 1'b0, 8'd0},   1'b1, '{18'h1FFFF, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd65536,  12'd4095, 1'b1, 1'b0, 8'd0},   1'b1, '{18'h10000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd1,      12'd4095, 1'b1, 1'b1, 8'd1},   1'b1, '{18'h00001, 1'b1, 1'b0, 20'd0, 1'b1}},
        // Target posterior of zero reads as the smallest code: loss is 16 * ln 2.
        // 18'h30000 is -1.0 in signed Q1.16.
        '{'{17'd65536,  12'd1,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h10000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd1,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h30000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd1,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b0, 1'b0, 20'd0, 1'b0}},
        '{'{17'd0,      12'd1,    1'b1, 1'b0, 8'd0},   1'b1, '{18'h00000, 1'b1, 1'b0, 20'd726816,
                                                                  1'b0}},
        // Tie for the maximum: the first index wins, so the frame is not correct.
        '{'{17'd100,    12'd2,    1'b1, 1'b0, 8'd0},   1'b0, '0},
        '{'{17'd200,    12'd2,    1'b1, 1'b0, 8'd0},   1'b0, '0},
        '{'{17'd200,    12'd2,    1'b1, 1'b0, 8'd0},   1'b0, '0},
        '{'{17'd50,     12'd2,    1'b1, 1'b1, 8'd37},  1'b0, '0},
        // Target and mask change within the frame.
        '{'{17'd3000,   12'd2,    1'b0, 1'b0, 8'd0},   1'b0, '0},
        '{'{17'd40000,  12'd1,    1'b1, 1'b0, 8'd0},   1'b0, '0},
        '{'{17'd20000,  12'd1,    1'b1, 1'b0, 8'd0},   1'b0, '0},
        '{'{17'd2000,   12'd0,    1'b1, 1'b0, 8'd200}, 1'b0, '0},
        // Half a frame; the class count drops to 2 before the next element.
        '{'{17'd5,      12'd3,    1'b1, 1'b0, 8'd0},   1'b0, '0},
        '{'{17'd60000,  12'd3,    1'b1, 1'b0, 8'd0},   1'b0, '0}
    };

    // DUT ports. Every input has a known value from time zero.
    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    s_axis_tuser  = 1'b0;
    logic                    s_axis_tlast  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [PADDR_W-1:0]      paddr         = '0;
    logic [PDATA_W-1:0]      pwdata        = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;

    // Predictor state: a private copy of the core's frame tracker and totals.
    logic [CNT_W-1:0]        cfg_class_count = CLASS_COUNT_RESET;
    logic [POS_W-1:0]        pr_position     = '0;
    logic [POST_W-1:0]       pr_best_value   = '0;
    logic [POS_W-1:0]        pr_best_index   = '0;
    logic [POST_W-1:0]       pr_target_post  = '0;
    longint unsigned         pr_loss_sum     = 0;
    longint unsigned         pr_correct      = 0;
    longint unsigned         pr_frames       = 0;
    longint unsigned         pr_sequences    = 0;
    int unsigned             ln_frac_q16 [TAB_SIZE];

    // Results predicted at input acceptance, oldest first.
    ce_expect_t              ce_results_due [$];

    int                      fail_count    = 0;
    bit                      tx_gappy      = 1'b0;
    int                      burst_left    = 0;
    int                      rx_mode       = 0;
    bit                      long_stall_go = 1'b0;

    cross_entropy_loss_gradient_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 clk = ~clk;

    // ln(1 + i/2^B) in Q.16 from the integer atanh series: ln(1+u) = 2 atanh(u/(2+u)).
    function automatic int unsigned ln1p_entry(input int i);
        longint unsigned z;
        longint unsigned zsq;
        longint unsigned term;
        longint unsigned acc;
        z    = (longint'(i) << 30) / longint'(2 * TAB_SIZE + i);
        zsq  = (z * z) >> 30;
        term = z;
        acc  = 0;
        for (int k = 0; k < 20; k++)
        begin
            acc  = acc + term / longint'(2 * k + 1);
            term = (term * zsq) >> 30;
        end
        return int'((2 * acc + 64'd8192) >> 14);
    endfunction

    // -ln(p) in Q4.16: normalize p into [1, 2), then s * ln 2 minus the table entry.
    function automatic int unsigned neg_ln_q16(input logic [POST_W-1:0] p);
        int unsigned x;
        int          shift;
        int          idx;
        longint      v;
        x     = (p == '0) ? 1 : int'(p);
        shift = 0;
        while (x < ONE_Q16)
        begin
            x     = x << 1;
            shift = shift + 1;
        end
        idx = (x >> (16 - LOG_TABLE_BITS)) & (TAB_SIZE - 1);
        v   = longint'(shift) * LN2_Q16 - longint'(ln_frac_q16[idx]);
        if (v < 0)
            v = 0;
        if (v > (1 << LOSS_W) - 1)
            v = (1 << LOSS_W) - 1;
        return int'(v);
    endfunction

    function automatic int classes_in_use(input logic [CNT_W-1:0] c);
        if (c < CNT_W'(MIN_CLASSES))
            return MIN_CLASSES;
        if (c > CNT_W'(MAX_CLASSES))
            return MAX_CLASSES;
        return int'(c);
    endfunction

    function automatic longint unsigned sat_add(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned cap);
        longint unsigned s;
        s = a + b;
        return (s > cap) ? cap : s;
    endfunction

    // Advances the predictor by one accepted element and returns its result.
    function automatic ce_expect_t predict_ce_element(input celg_item_t it);
        ce_expect_t r;
        int         cnt;
        int         pos;
        int         grad;
        bit         hit;
        r   = '0;
        cnt = classes_in_use(cfg_class_count);
        pos = int'(pr_position);

        // Argmax keeps the first index of the maximum; the target posterior is
        // cleared at frame start and follows the last matching element.
        if (pos == 0)
        begin
            pr_best_value  = it.posterior;
            pr_best_index  = '0;
            pr_target_post = '0;
        end
        else if (it.posterior > pr_best_value)
        begin
            pr_best_value = it.posterior;
            pr_best_index = POS_W'(pos);
        end
        hit = (pos == int'(it.target_class));
        if (hit)
            pr_target_post = it.posterior;

        grad = int'(it.posterior) - (hit ? ONE_Q16 : 0);
        if (!it.frame_mask)
            grad = 0;
        r.el.gradient  = GRAD_W'(grad);
        r.el.frame_end = (pos + 1 >= cnt);

        if (r.el.frame_end)
        begin
            r.el.class_error = (int'(it.target_class) >= cnt);
            if (!r.el.class_error)
            begin
                r.el.frame_correct = it.frame_mask && (pr_best_index == it.target_class);
                r.el.frame_loss    = it.frame_mask ? LOSS_W'(neg_ln_q16(pr_target_post)) : '0;
            end
            pr_loss_sum = sat_add(pr_loss_sum, longint'(r.el.frame_loss), 64'hFFFF_FFFF_FFFF);
            pr_correct  = sat_add(pr_correct, longint'(r.el.frame_correct), 64'hFFFF_FFFF);
            pr_frames   = sat_add(pr_frames, 1, 64'hFFFF_FFFF);
            if (it.call_end)
                pr_sequences = sat_add(pr_sequences, longint'(it.sequences_add),
                                       64'hFFFF_FFFF);
            pr_position = '0;
        end
        else
        begin
            pr_position = POS_W'(pos + 1);
        end

        r.tot.total_loss      = TOTAL_LOSS_W'(pr_loss_sum);
        r.tot.total_correct   = COUNT_W'(pr_correct);
        r.tot.total_frames    = COUNT_W'(pr_frames);
        r.tot.total_sequences = COUNT_W'(pr_sequences);
        return r;
    endfunction

    function automatic void cmp_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Offers one input transaction and holds it until the core takes it. The
    // expectation is queued at the accepting edge. In gappy mode the sender drops
    // tvalid for a random gap at the end of each random-length burst.
    task automatic push_item(input celg_item_t it, input bit typed,
                             input celg_result_t typed_el);
        ce_expect_t e;
        int         gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({it.sequences_add, it.target_class, it.posterior});
        s_axis_tuser  <= it.frame_mask;
        s_axis_tlast  <= it.call_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        e = predict_ce_element(it);
        if (typed)
            e.el = typed_el;
        ce_results_due.push_back(e);

        if (tx_gappy)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // Stops offering input and waits until every predicted result has been seen.
    // Each element yields exactly one result, so the pipe is empty afterwards.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (ce_results_due.size() != 0)
            @(posedge clk);
    endtask

    // One APB transfer to the class_count register: setup cycle, then access cycle.
    task automatic apb_xfer(input bit wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CLASS_COUNT_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr)
            cfg_class_count = wdata[CNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Class count changes only with the core idle; the written value is read back.
    task automatic set_class_count(input logic [CNT_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        drain_results();
        apb_xfer(1'b1, PDATA_W'(val), rd);
        apb_xfer(1'b0, '0, rd);
        cmp_field("class_count readback", 64'(val), 64'(rd));
    endtask

    // The first len elements of one frame of random content. Most frames are
    // softmax-like, with the target often holding the peak; some carry an out-of-range
    // target, a target that wanders between elements, extremes or raw 17-bit noise.
    task automatic send_random_frame(input int cnt, input int len);
        celg_item_t it;
        int         tgt;
        bit         peaked;
        bit         drifting;
        bit         mask;
        int         r;
        if ($urandom_range(0, 99) < 8 && cnt < MAX_CLASSES)
            tgt = $urandom_range(cnt, MAX_CLASSES - 1);
        else
            tgt = $urandom_range(0, cnt - 1);
        peaked   = ($urandom_range(0, 9) < 6);
        drifting = ($urandom_range(0, 19) == 0);
        mask     = ($urandom_range(0, 4) != 0);

        for (int e = 0; e < len; e++)
        begin
            it.target_class  = drifting ? POS_W'($urandom_range(0, cnt - 1)) : POS_W'(tgt);
            it.frame_mask    = mask ^ ($urandom_range(0, 19) == 0);
            it.call_end      = ($urandom_range(0, 3) == 0);
            it.sequences_add = SEQ_ADD_W'($urandom);
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       it.posterior = 17'd0;
                    1:       it.posterior = 17'd1;
                    2:       it.posterior = 17'd65535;
                    3:       it.posterior = 17'd65536;
                    default: it.posterior = 17'd131071;
                endcase
            end
            else if (r == 1)
            begin
                it.posterior = POST_W'($urandom);
            end
            else if (peaked && e == tgt)
            begin
                it.posterior = POST_W'($urandom_range(20000, ONE_Q16));
            end
            else
            begin
                it.posterior = POST_W'($urandom_range(0, 2 * ONE_Q16 / cnt));
            end
            push_item(it, 1'b0, '0);
        end
    endtask

    // Receiver. Modes: always ready, a fixed rotating pattern, or random stalls.
    // A long hold-off is counted here so that the sender keeps pushing into a full pipe.
    initial
    begin : rx_ready_gen
        int pat_idx;
        pat_idx = 0;
        forever
        begin
            @(negedge clk);
            if (long_stall_go)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge clk);
                long_stall_go = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= RX_PATTERN[pat_idx];
                    default: m_axis_tready <= ($urandom_range(0, 9) < 6);
                endcase
                pat_idx = (pat_idx + 1) % 16;
            end
        end
    end

    // Every output transaction is compared field by field with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        ce_expect_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (ce_results_due.size() == 0)
            begin
                $error("output transaction with no expected result pending");
                fail_count++;
            end
            else
            begin
                want = ce_results_due.pop_front();
                cmp_field("gradient", 64'(want.el.gradient), 64'(m_axis_tdata[0 +: GRAD_W]));
                cmp_field("frame_end", 64'(want.el.frame_end), 64'(m_axis_tlast));
                cmp_field("frame_correct", 64'(want.el.frame_correct), 64'(m_axis_tuser[0]));
                cmp_field("frame_loss", 64'(want.el.frame_loss),
                          64'(m_axis_tdata[LOSS_LO +: LOSS_W]));
                cmp_field("class_error", 64'(want.el.class_error), 64'(m_axis_tuser[1]));
                cmp_field("total_loss", 64'(want.tot.total_loss),
                          64'(m_axis_tdata[TLOSS_LO +: TOTAL_LOSS_W]));
                cmp_field("total_correct", 64'(want.tot.total_correct),
                          64'(m_axis_tdata[TCORR_LO +: COUNT_W]));
                cmp_field("total_frames", 64'(want.tot.total_frames),
                          64'(m_axis_tdata[TFRM_LO +: COUNT_W]));
                cmp_field("total_sequences", 64'(want.tot.total_sequences),
                          64'(m_axis_tdata[TSEQ_LO +: COUNT_W]));
            end
        end
    end

    // Main sequence: reset, reset-value check, directed table, random phases, drain.
    initial
    begin : main_seq
        logic [PDATA_W-1:0] rd;
        int                 cnt;
        int                 sent;
        int                 budget;
        int                 len;
        for (int i = 0; i < TAB_SIZE; i++)
            ln_frac_q16[i] = ln1p_entry(i);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The class count comes out of reset at its maximum.
        apb_xfer(1'b0, '0, rd);
        cmp_field("class_count after reset", 64'd4096, 64'(rd));

        // Directed part with bursty input and a receiver that never stalls.
        set_class_count(13'd4);
        tx_gappy = 1'b1;
        rx_mode  = 0;
        for (int i = 0; i < DIR_ROWS; i++)
            push_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].el);

        // Random phases. The first one runs without any idling; two of them start with
        // a long receiver hold-off while the sender keeps offering transactions. With a
        // very large class count only the first part of one frame is sent, and the
        // next phase's smaller count ends that frame on its first element.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            set_class_count(PHASE_CFG[ph]);
            cnt        = classes_in_use(PHASE_CFG[ph]);
            budget     = PHASE_ITEMS;
            tx_gappy   = (ph != 0) && ($urandom_range(0, 2) != 0);
            burst_left = $urandom_range(0, 15);
            rx_mode    = (ph == 0) ? 0 : $urandom_range(0, 2);
            if (ph == 3 || cnt >= 1000)
            begin
                tx_gappy      = 1'b0;
                long_stall_go = 1'b1;
            end
            sent = 0;
            while (sent < budget)
            begin
                len = (cnt >= 1000) ? budget : cnt;
                send_random_frame(cnt, len);
                sent += len;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
